>>> rtl/core/cfsf_pkg.sv
// shared types, record constants and crc helper for the can frame serial framer
// no dependencies

package cfsf_pkg;

	localparam int REC_LEN         = 27;
	localparam int CRC_SPAN        = 20;
	localparam int CRC_STAGES      = 5;
	localparam int BYTES_PER_STAGE = CRC_SPAN / CRC_STAGES;
	localparam int BODY_W          = CRC_SPAN * 8;

	localparam logic [7:0]  START_BYTE = 8'h69;
	localparam logic [7:0]  CR_BYTE    = 8'h0D;
	localparam logic [7:0]  LF_BYTE    = 8'h0A;
	localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

	// byte positions within the record
	localparam logic [4:0] IDX_START     = 5'd0;
	localparam logic [4:0] IDX_BODY0     = 5'd1;
	localparam logic [4:0] IDX_BODY_LAST = 5'd20;
	localparam logic [4:0] IDX_CRC0      = 5'd21;
	localparam logic [4:0] IDX_CRC_LAST  = 5'd24;
	localparam logic [4:0] IDX_CR        = 5'd25;
	localparam logic [4:0] IDX_LF        = 5'd26;

	typedef struct packed {
		logic [31:0] timestamp_us;
		logic [28:0] can_identifier;
		logic        extended_frame;
		logic [3:0]  data_length;
		logic [63:0] payload;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_record;
	} out_item_t;

	// crc-covered bytes (byte 0 in the low bits) and running crc
	typedef struct packed {
		logic [BODY_W-1:0] body;
		logic [31:0]       crc;
	} rec_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/cfsf_crc_pipe.sv
// crc pipeline: folds the record body into the running crc, a few bytes per stage
// depends on cfsf_pkg

module cfsf_crc_pipe (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cfsf_pkg::rec_t in_rec,
	output logic          out_valid,
	input  logic          out_ready,
	output cfsf_pkg::rec_t out_rec
);

	localparam int N  = cfsf_pkg::CRC_STAGES;
	localparam int BP = cfsf_pkg::BYTES_PER_STAGE;

	logic [N-1:0]    valid_s;
	logic [N-1:0]    stage_ready;
	cfsf_pkg::rec_t  data_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic           prev_valid;
		logic           next_ready;
		cfsf_pkg::rec_t prev_rec;
		logic [31:0]    crc_next;

		if (k == 0) begin : g_first
			assign prev_valid = in_valid;
			assign prev_rec   = in_rec;
		end else begin : g_mid
			assign prev_valid = valid_s[k-1];
			assign prev_rec   = data_s[k-1];
		end

		if (k == N - 1) begin : g_last
			assign next_ready = out_ready;
		end else begin : g_next
			assign next_ready = stage_ready[k+1];
		end

		assign stage_ready[k] = !valid_s[k] || next_ready;

		always_comb begin
			crc_next = prev_rec.crc;
			for (int j = 0; j < BP; j++) begin
				crc_next = cfsf_pkg::crc_byte(crc_next, prev_rec.body[8*(BP*k+j) +: 8]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (stage_ready[k]) begin
				valid_s[k] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (stage_ready[k] && prev_valid) begin
				data_s[k].body <= prev_rec.body;
				data_s[k].crc  <= crc_next;
			end
		end
	end

	assign in_ready  = stage_ready[0];
	assign out_valid = valid_s[N-1];
	assign out_rec   = data_s[N-1];

endmodule

>>> rtl/core/cfsf_ser.sv
// byte serializer: holds one finished record and sends it out a byte per cycle while out_ready is high
// depends on cfsf_pkg

module cfsf_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cfsf_pkg::rec_t     in_rec,
	output logic               out_valid,
	input  logic               out_ready,
	output cfsf_pkg::out_item_t out_item
);

	logic                        busy_q;
	logic [4:0]                  idx_q;
	logic [cfsf_pkg::BODY_W-1:0] body_q;
	logic [31:0]                 crc_q;
	logic [4:0]                  body_sel;
	logic [4:0]                  crc_sel;
	logic                        at_last;
	logic                        take;

	assign at_last  = (idx_q == cfsf_pkg::IDX_LF);
	assign in_ready = !busy_q || (out_ready && at_last);
	assign take     = in_valid && in_ready;
	assign body_sel = idx_q - cfsf_pkg::IDX_BODY0;
	assign crc_sel  = idx_q - cfsf_pkg::IDX_CRC0;

	always_comb begin
		out_item.last_of_record = at_last;
		case (idx_q) inside
			[cfsf_pkg::IDX_BODY0:cfsf_pkg::IDX_BODY_LAST]:
				out_item.out_byte = body_q[{body_sel, 3'b000} +: 8];
			[cfsf_pkg::IDX_CRC0:cfsf_pkg::IDX_CRC_LAST]:
				out_item.out_byte = crc_q[{crc_sel[1:0], 3'b000} +: 8];
			cfsf_pkg::IDX_CR:
				out_item.out_byte = cfsf_pkg::CR_BYTE;
			cfsf_pkg::IDX_LF:
				out_item.out_byte = cfsf_pkg::LF_BYTE;
			default:
				out_item.out_byte = cfsf_pkg::START_BYTE;
		endcase
	end

	assign out_valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= cfsf_pkg::IDX_START;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= cfsf_pkg::IDX_START;
		end else if (busy_q && out_ready) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			body_q <= in_rec.body;
			crc_q  <= ~in_rec.crc;
		end
	end

endmodule

>>> rtl/core/can_frame_serial_framer_crc32_unit.sv
// top level of the can frame serial framer with crc-32
// depends on cfsf_pkg, cfsf_crc_pipe and cfsf_ser

// Takes one received CAN message per item and sends it as a 27-byte serial
// record: start byte 0x69, timestamp (little endian), identifier (little
// endian, bit 31 set for extended frames), raw length byte, three zero pads,
// eight data bytes (zero at or beyond the length), the reflected CRC-32 of
// the twenty bytes after the start byte (little endian), then CR and LF.
// Rate: one byte per cycle at the output while out_ready is high, set by
// the single-byte output serializer; with out_ready held high records follow
// each other with no gap. From acceptance to the start byte a message passes
// one assembly stage, five crc stages of four bytes and the serializer load.
// in_ready stays high while the pipeline has room, so up to seven messages
// can be held behind a stalled output, six of them queued behind the record
// being sent. No configuration, no reset-time sweep.

module can_frame_serial_framer_crc32_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cfsf_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output cfsf_pkg::out_item_t out_item
);

	// assembly stage
	logic           valid_s1;
	cfsf_pkg::rec_t rec_s1;
	cfsf_pkg::rec_t rec_next;
	logic           pipe_in_ready;
	logic [63:0]    data_masked;
	logic [31:0]    ident_word;

	// crc pipeline to serializer
	logic           pipe_valid;
	logic           ser_ready;
	cfsf_pkg::rec_t pipe_rec;

	// data bytes at or beyond the length go out as zero
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			data_masked[8*i +: 8] = (4'(i) < in_item.data_length) ?
				in_item.payload[8*i +: 8] : 8'h00;
		end
	end

	// extended flag lands in bit 31 of the identifier word
	assign ident_word = {in_item.extended_frame, 2'b00, in_item.can_identifier};

	// body byte 0 is record byte 1
	assign rec_next.body = {data_masked, 24'h000000, 4'h0, in_item.data_length,
		ident_word, in_item.timestamp_us};
	assign rec_next.crc  = cfsf_pkg::CRC_INIT;

	assign in_ready = !valid_s1 || pipe_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rec_s1 <= rec_next;
		end
	end

	// crc folding, four bytes per stage
	cfsf_crc_pipe u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (pipe_in_ready),
		.in_rec    (rec_s1),
		.out_valid (pipe_valid),
		.out_ready (ser_ready),
		.out_rec   (pipe_rec)
	);

	// record output, next record loads as the line feed is taken
	cfsf_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pipe_valid),
		.in_ready  (ser_ready),
		.in_rec    (pipe_rec),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> rtl/core/cfsf_checker.sv
// port-level checks for the can frame serial framer, bound to the top level
// depends on cfsf_pkg and can_frame_serial_framer_crc32_unit

module cfsf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input cfsf_pkg::out_item_t out_item
);

	// a stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output item changed while stalled");

	// the record ends on a line feed
	a_last_lf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last_of_record |-> out_item.out_byte == cfsf_pkg::LF_BYTE)
		else $error("last byte is not a line feed");

	// a record that follows directly opens with the start byte
	a_next_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.last_of_record |=>
		!out_valid || (out_item.out_byte == cfsf_pkg::START_BYTE && !out_item.last_of_record))
		else $error("record does not open with the start byte");

	// with the output idle the pipeline drains, so input is never blocked
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output idle");

endmodule

bind can_frame_serial_framer_crc32_unit cfsf_checker u_cfsf_checker (.*);
